FILE: sv/rpsv_pkg.sv
// Shared types and constants for the resource pack stream validator.
// No dependencies; every other file except rpsv_if imports this package.
package rpsv_pkg;

    localparam int POSITION_WIDTH = 40;
    localparam int LIMIT_WIDTH    = 17;
    localparam int SUM_WIDTH      = 64;
    localparam int CFG_IDX_WIDTH  = 1;

    localparam logic [LIMIT_WIDTH-1:0] HARD_LIMIT = 17'd65536;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_ENTRIES   = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_NAME_SIZE = 1'b1;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_TOO_SHORT    = 4'd1,
        ERR_RECORDS_LOW  = 4'd2,
        ERR_BAD_COUNT    = 4'd3,
        ERR_DESC_OVERRUN = 4'd4,
        ERR_BAD_NAMESIZE = 4'd5,
        ERR_BAD_NAME     = 4'd6,
        ERR_RECORDS_MISM = 4'd7,
        ERR_PAYLOAD_MISM = 4'd8
    } err_t;

    // End-of-file snapshot handed from the parser to the verdict stage
    typedef struct packed {
        logic [POSITION_WIDTH-1:0] size;
        logic [POSITION_WIDTH-1:0] records_end;
        err_t                      first_error;
        logic                      at_tail;
        logic [SUM_WIDTH-1:0]      payload_sum;
        logic [LIMIT_WIDTH-1:0]    header_count;
    } snap_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

endpackage

FILE: sv/rpsv_if.sv
// Handshake interfaces for the byte stream and the verdict stream.
// Does not import rpsv_pkg; its field widths are written out as literals.
interface rpsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpsv_result_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [3:0]  error_code;
    logic [16:0] entries_read;
    logic [32:0] payload_start;
    modport source (output valid, output valid_res, output error_code, output entries_read,
                    output payload_start, input ready);
    modport sink (input valid, input valid_res, input error_code, input entries_read,
                  input payload_start, output ready);
endinterface

FILE: sv/rpsv_parser.sv
// Front end: one byte per cycle unless stalled; tracks layout and flags the first error.
// Depends on rpsv_pkg and rpsv_byte_if; pushes an end-of-file snapshot into the queue.
module rpsv_parser
    import rpsv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    rpsv_byte_if.sink                byte_in,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [LIMIT_WIDTH-1:0]   cfg_data,
    input  q_status_t                q_status,
    output logic                     push,
    output snap_t                    snap
);

    typedef enum logic [6:0] {
        PH_RECSIZE  = 7'b0000001,
        PH_COUNT    = 7'b0000010,
        PH_PAYSIZE  = 7'b0000100,
        PH_NAMESIZE = 7'b0001000,
        PH_NAME     = 7'b0010000,
        PH_TAIL     = 7'b0100000,
        PH_HALT     = 7'b1000000
    } phase_t;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    phase_t                    phase_reg, phase_next;
    logic [1:0]                idx_reg, idx_next;
    logic [23:0]               shift_reg, shift_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] rend_reg, rend_next;
    logic [LIMIT_WIDTH-1:0]    left_reg, left_next;
    logic [LIMIT_WIDTH-1:0]    count_reg, count_next;
    logic [LIMIT_WIDTH-1:0]    nleft_reg, nleft_next;
    logic [1:0]                pend_reg, pend_next;
    logic [20:0]               rune_reg, rune_next;
    logic                      vis_reg, vis_next;
    logic [SUM_WIDTH-1:0]      sum_reg, sum_next;
    err_t                      err_reg, err_next;
    logic [LIMIT_WIDTH-1:0]    max_ent_reg, max_name_reg;

    logic                      accept;
    logic [LIMIT_WIDTH-1:0]    cap_ent, cap_name;
    logic [POSITION_WIDTH-1:0] nxt;
    logic [31:0]               v;
    logic [7:0]                b;
    logic                      byte_ok;
    logic                      rune_done;
    logic [20:0]               rune;
    logic                      rune_bad;

    assign byte_in.ready = q_status.not_full;
    assign accept        = byte_in.valid & byte_in.ready;
    assign b             = byte_in.data_byte;
    assign cap_ent       = (max_ent_reg > HARD_LIMIT) ? HARD_LIMIT : max_ent_reg;
    assign cap_name      = (max_name_reg > HARD_LIMIT) ? HARD_LIMIT : max_name_reg;
    assign nxt           = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign v             = {b, shift_reg};

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        rend_next  = rend_reg;
        left_next  = left_reg;
        count_next = count_reg;
        nleft_next = nleft_reg;
        pend_next  = pend_reg;
        rune_next  = rune_reg;
        vis_next   = vis_reg;
        sum_next   = sum_reg;
        err_next   = err_reg;
        byte_ok    = 1'b1;
        rune_done  = 1'b0;
        rune       = 21'(b);
        rune_bad   = 1'b0;

        // descriptor must start at least four bytes before the records end
        if ((phase_reg == PH_PAYSIZE || phase_reg == PH_NAMESIZE) && idx_reg == 2'd0 &&
            (65'(pos_reg) + 65'd4 > 65'(rend_reg)))
        begin
            err_next   = ERR_DESC_OVERRUN;
            phase_next = PH_HALT;
        end

        if (phase_next inside {PH_RECSIZE, PH_COUNT, PH_PAYSIZE, PH_NAMESIZE})
        begin
            if (idx_reg != 2'd3)
            begin
                shift_next[idx_reg*8 +: 8] = b;
                idx_next = idx_reg + 2'd1;
            end
            else
            begin
                idx_next   = 2'd0;
                shift_next = '0;
                case (phase_next)
                    PH_RECSIZE:
                    begin
                        rend_next = POSITION_WIDTH'(v) + POSITION_WIDTH'(4);
                        if (v < 32'd4)
                        begin
                            err_next   = ERR_RECORDS_LOW;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (v == 32'd0 || v > 32'(cap_ent))
                        begin
                            err_next   = ERR_BAD_COUNT;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            count_next = v[LIMIT_WIDTH-1:0];
                            left_next  = v[LIMIT_WIDTH-1:0];
                            phase_next = PH_PAYSIZE;
                        end
                    end
                    PH_PAYSIZE:
                    begin
                        sum_next   = sum_reg + SUM_WIDTH'(v);
                        phase_next = PH_NAMESIZE;
                    end
                    default:
                    begin
                        if (v == 32'd0 || v > 32'(cap_name) ||
                            (65'(nxt) + 65'(v) > 65'(rend_reg)))
                        begin
                            err_next   = ERR_BAD_NAMESIZE;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            nleft_next = v[LIMIT_WIDTH-1:0];
                            pend_next  = 2'd0;
                            rune_next  = '0;
                            vis_next   = 1'b0;
                            phase_next = PH_NAME;
                        end
                    end
                endcase
            end
        end
        else if (phase_next == PH_NAME)
        begin
            // UTF-8 decode: lead byte opens a sequence, continuations fill it
            if (pend_reg == 2'd0)
            begin
                if (b < 8'h80)
                begin
                    rune_done = 1'b1;
                end
                else if ((b & 8'hE0) == 8'hC0)
                begin
                    rune_next = 21'(b & 8'h1F);
                    pend_next = 2'd1;
                end
                else if ((b & 8'hF0) == 8'hE0)
                begin
                    rune_next = 21'(b & 8'h0F);
                    pend_next = 2'd2;
                end
                else if ((b & 8'hF8) == 8'hF0)
                begin
                    rune_next = 21'(b & 8'h07);
                    pend_next = 2'd3;
                end
                else
                begin
                    byte_ok = 1'b0;
                end
            end
            else if ((b & 8'hC0) != 8'h80)
            begin
                byte_ok = 1'b0;
            end
            else
            begin
                rune_next = {rune_reg[14:0], b[5:0]};
                pend_next = pend_reg - 2'd1;
                rune      = rune_next;
                rune_done = (pend_next == 2'd0);
            end

            if (rune_done)
            begin
                rune_bad = (rune == 21'd0) || (rune < 21'h20 && rune != 21'h09) ||
                           (rune == 21'h7F);
                if (rune_bad)
                begin
                    byte_ok = 1'b0;
                end
                else if (rune != 21'h20 && rune != 21'h09)
                begin
                    vis_next = 1'b1;
                end
            end

            if (!byte_ok)
            begin
                err_next   = ERR_BAD_NAME;
                phase_next = PH_HALT;
            end
            else
            begin
                nleft_next = nleft_reg - 1'b1;
                if (nleft_next == '0)
                begin
                    if (pend_next != 2'd0 || !vis_next)
                    begin
                        err_next   = ERR_BAD_NAME;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        left_next = left_reg - 1'b1;
                        if (left_next != '0)
                        begin
                            phase_next = PH_PAYSIZE;
                        end
                        else if (nxt != rend_reg)
                        begin
                            err_next   = ERR_RECORDS_MISM;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                end
            end
        end
        pos_next = nxt;
    end

    assign push               = accept & byte_in.last_byte;
    assign snap.size          = pos_next;
    assign snap.records_end   = rend_next;
    assign snap.first_error   = err_next;
    assign snap.at_tail       = (phase_next == PH_TAIL);
    assign snap.payload_sum   = sum_next;
    assign snap.header_count  = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ent_reg  <= HARD_LIMIT;
            max_name_reg <= HARD_LIMIT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_ENTRIES)
            begin
                max_ent_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAX_NAME_SIZE)
            begin
                max_name_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RECSIZE;
            idx_reg   <= '0;
            shift_reg <= '0;
            pos_reg   <= '0;
            rend_reg  <= '0;
            left_reg  <= '0;
            count_reg <= '0;
            nleft_reg <= '0;
            pend_reg  <= '0;
            rune_reg  <= '0;
            vis_reg   <= 1'b0;
            sum_reg   <= '0;
            err_reg   <= ERR_NONE;
        end
        else if (accept)
        begin
            if (byte_in.last_byte)
            begin
                // file done: restart for the next one
                phase_reg <= PH_RECSIZE;
                idx_reg   <= '0;
                shift_reg <= '0;
                pos_reg   <= '0;
                rend_reg  <= '0;
                left_reg  <= '0;
                count_reg <= '0;
                nleft_reg <= '0;
                pend_reg  <= '0;
                rune_reg  <= '0;
                vis_reg   <= 1'b0;
                sum_reg   <= '0;
                err_reg   <= ERR_NONE;
            end
            else
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                shift_reg <= shift_next;
                pos_reg   <= pos_next;
                rend_reg  <= rend_next;
                left_reg  <= left_next;
                count_reg <= count_next;
                nleft_reg <= nleft_next;
                pend_reg  <= pend_next;
                rune_reg  <= rune_next;
                vis_reg   <= vis_next;
                sum_reg   <= sum_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

FILE: sv/rpsv_queue.sv
// Two-entry queue of end-of-file snapshots between parser and verdict stage.
// Depends on rpsv_pkg.
module rpsv_queue
    import rpsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  snap_t     push_data,
    input  logic      pop,
    output snap_t     head,
    output q_status_t status
);

    snap_t      mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign status.not_empty = (cnt_reg != 2'd0);
    assign status.not_full  = (cnt_reg != 2'd2);
    assign head             = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: sv/rpsv_verdict.sv
// Back end: ranks the end-of-file checks into one error code and holds the result.
// Depends on rpsv_pkg and rpsv_result_if.
module rpsv_verdict
    import rpsv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  snap_t         head,
    input  q_status_t     q_status,
    output logic          pop,
    rpsv_result_if.source verdict_out
);

    logic                  out_valid_reg;
    logic                  res_reg;
    err_t                  code_reg;
    logic [16:0]           count_reg;
    logic [32:0]           start_reg;
    err_t                  code;
    logic [SUM_WIDTH-1:0]  tail_len;

    assign pop      = q_status.not_empty & (~out_valid_reg | verdict_out.ready);
    assign tail_len = SUM_WIDTH'(head.size) - SUM_WIDTH'(head.records_end);

    always_comb
    begin
        if (head.size < POSITION_WIDTH'(8))
            code = ERR_TOO_SHORT;
        else if (head.first_error == ERR_RECORDS_LOW)
            code = ERR_RECORDS_LOW;
        else if (head.records_end > head.size)
            code = ERR_TOO_SHORT;
        else if (head.first_error != ERR_NONE)
            code = head.first_error;
        else if (!head.at_tail)
            code = ERR_DESC_OVERRUN;
        else if (head.payload_sum != tail_len)
            code = ERR_PAYLOAD_MISM;
        else
            code = ERR_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg   <= (code == ERR_NONE);
            code_reg  <= code;
            count_reg <= head.header_count;
            start_reg <= 33'(head.records_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign verdict_out.valid         = out_valid_reg;
    assign verdict_out.valid_res     = res_reg;
    assign verdict_out.error_code    = code_reg;
    assign verdict_out.entries_read  = count_reg;
    assign verdict_out.payload_start = start_reg;

endmodule

FILE: sv/resource_pack_stream_validator.sv
// Top level of the resource pack stream validator: parser, snapshot queue, verdict stage.
// Depends on rpsv_pkg, rpsv_if, rpsv_parser, rpsv_queue and rpsv_verdict.
//
// channel      dir  transaction           fields
// byte_in      in   one file byte         data_byte[7:0], last_byte
// verdict_out  out  one verdict per file  valid_res, error_code[3:0],
//                                         entries_read[16:0], payload_start[32:0]
// cfg          in   register write        cfg_we, cfg_index[0:0], cfg_data[16:0]
//
// One byte per cycle while byte_in is not stalled; the parser's per-byte state update sets the rate.
// After the edge that takes its last byte, a verdict passes through the queue entry and then
// the output register; a stalled verdict_out holds it in the queue.
// Reset restores both limits to 65536 and clears the parser; no clearing pass.
// byte_in stalls only when two verdicts wait behind a stalled verdict_out.
module resource_pack_stream_validator
    import rpsv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    rpsv_byte_if.sink                byte_in,
    rpsv_result_if.source            verdict_out,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [LIMIT_WIDTH-1:0]   cfg_data
);

    q_status_t q_status;
    logic      push, pop;
    snap_t     snap, head;

    rpsv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .snap      (snap)
    );

    rpsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (snap),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    rpsv_verdict u_verdict (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .verdict_out (verdict_out)
    );

endmodule
